@@ hw/rtl/pdcd_pkg.sv @@
package pdcd_pkg;

  localparam int NUM_ENTRIES_DEF = 64;
  localparam int NUM_DEVICES     = 64;

  localparam int IDX_W  = 6;
  localparam int DEV_W  = 6;
  localparam int OFF_W  = 3;
  localparam int LEN_W  = 7;
  localparam int DATA_W = 64;
  localparam int HI_W   = 8;

  // field lengths that compare as signed values (8, 16, 32), and the widest field length
  localparam logic [LEN_W-1:0] LEN_S8  = LEN_W'(8);
  localparam logic [LEN_W-1:0] LEN_S16 = LEN_W'(16);
  localparam logic [LEN_W-1:0] LEN_S32 = LEN_W'(32);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(64);

  typedef enum logic {
    REQ_REGISTER = 1'b0,
    REQ_CHECK    = 1'b1
  } req_kind_t;

  typedef enum logic [2:0] {
    OUT_REGISTERED   = 3'd0,
    OUT_UNREGISTERED = 3'd1,
    OUT_OUTPUT       = 3'd2,
    OUT_RATE_LIMITED = 3'd3,
    OUT_INITIAL      = 3'd4,
    OUT_CHANGED      = 3'd5,
    OUT_UNCHANGED    = 3'd6
  } outcome_t;

  typedef struct packed {
    req_kind_t          req_type;
    logic [IDX_W-1:0]   slot;
    logic [DEV_W-1:0]   device_index;
    logic [OFF_W-1:0]   start_bit;
    logic [LEN_W-1:0]   field_len;
    logic               out_only;
    logic [DATA_W-1:0]  deadband;
    logic [DATA_W-1:0]  hold_off_ns;
    logic [DATA_W-1:0]  now_ns;
    logic [DATA_W-1:0]  window_lo;
    logic [HI_W-1:0]    window_hi;
  } req_t;

  typedef struct packed {
    outcome_t           outcome;
    logic [IDX_W-1:0]   report_entry;
    logic [DEV_W-1:0]   report_device;
    logic [DATA_W-1:0]  report_value;
  } rsp_t;

  // one table entry as held in the entry memory
  typedef struct packed {
    logic [OFF_W-1:0]   start_bit;
    logic [LEN_W-1:0]   field_len;
    logic               out_only;
    logic [DEV_W-1:0]   device;
    logic [DATA_W-1:0]  deadband;
    logic [DATA_W-1:0]  interval;
    logic [DATA_W-1:0]  shadow;
    logic [DATA_W-1:0]  last_time;
    logic               seen;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    rsp_t    rsp;
    logic    wr_en;
    logic    set_valid;
    entry_t  wr_word;
  } eval_t;

endpackage

@@ hw/rtl/pdcd_if.sv @@
interface pdcd_req_if import pdcd_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pdcd_rsp_if import pdcd_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/process_data_change_detector.sv @@
// process data change detector, report by exception with deadband
//
// req channel: one transfer per item; req_type selects registering an
// entry descriptor or checking an entry against a window of the process
// image. rsp channel: exactly one transfer per accepted item, in order.
//
// order: the entry memory is read at the request transfer, then the
// evaluation stage writes its result into the result register once that
// register is free or being emptied.
// throughput: one item per cycle while the receiver takes results, set by
// the single write port of the entry memory; a write-back bypass covers
// back-to-back items on the same entry.
//
// reset (synchronous, rst high): all entry valid bits clear together
// and both pipeline stages empty; no clearing pass runs over the memory.
//
// receiver stall: the result register holds, the evaluation stage holds
// its item and re-reads its entry, and req.ready drops once both are
// full; no result is dropped or repeated.
module process_data_change_detector import pdcd_pkg::*; #(
  parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
  input logic        clk,
  input logic        rst,
  pdcd_req_if.sink   req,
  pdcd_rsp_if.source rsp
);

  localparam int AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

  // evaluation stage
  logic             s1_valid;
  req_t             s1_item;
  logic [AW-1:0]    s1_addr;
  logic             s1_in_range;
  logic             s1_entry_on;
  logic             advance;
  logic             hold;

  // result register
  logic             out_valid;
  rsp_t             out_data;

  // per-entry valid bits in flops, cleared by reset
  logic [NUM_ENTRIES-1:0] entry_valid;

  // entry memory and write-back bypass
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               ram_we;
  logic               byp_valid;
  logic [AW-1:0]      byp_addr;
  entry_t             byp_word;
  entry_t             cur_word;
  eval_t              ev;

  assign s1_addr     = AW'(s1_item.slot);
  assign s1_in_range = 32'(s1_item.slot) < NUM_ENTRIES;
  assign s1_entry_on = s1_in_range && entry_valid[s1_addr];

  // stage moves when the result register is free or being emptied
  assign advance   = s1_valid && (!out_valid || rsp.ready);
  assign hold      = s1_valid && !advance;
  assign req.ready = !s1_valid || advance;

  // a stalled item keeps re-reading its own entry
  assign ram_raddr = hold ? s1_addr : AW'(req.data.slot);
  assign ram_we    = advance && ev.wr_en;

  // the word written last cycle is not yet in the read data
  assign cur_word = (byp_valid && byp_addr == s1_addr) ? byp_word : entry_t'(ram_rdata);

  pdcd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr),
    .wdata (ev.wr_word),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pdcd_eval u_eval (
    .item     (s1_item),
    .in_range (s1_in_range),
    .entry_on (s1_entry_on),
    .word     (cur_word),
    .res      (ev)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      byp_valid   <= 1'b0;
      entry_valid <= '0;
    end else begin
      if (req.valid && req.ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      byp_valid <= ram_we;
      if (advance && ev.set_valid) begin
        entry_valid[s1_addr] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_item <= req.data;
    end
    if (advance) begin
      out_data <= ev.rsp;
    end
    if (ram_we) begin
      byp_addr <= s1_addr;
      byp_word <= ev.wr_word;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  // a successful registration leaves its entry valid
  a_reg_sets_valid: assert property (@(posedge clk) disable iff (rst)
    advance && ev.set_valid |=> entry_valid[$past(s1_addr)])
    else $error("registered entry not marked valid");

  // a stalled item stays in the evaluation stage unchanged
  a_hold_keeps_item: assert property (@(posedge clk) disable iff (rst)
    hold |=> s1_valid && $stable(s1_item))
    else $error("stalled item lost from evaluation stage");

  // a value is reported only for initial and changed outcomes
  a_value_only_on_report: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.outcome == OUT_INITIAL || out_data.outcome == OUT_CHANGED
                   || out_data.report_value == '0))
    else $error("report value set on a non-reporting outcome");

  // reset leaves the table and the pipeline empty
  a_reset_clears: assert property (@(posedge clk)
    rst |=> entry_valid == '0 && !s1_valid && !out_valid)
    else $error("reset did not clear table and pipeline");

endmodule

@@ hw/rtl/pdcd_ram.sv @@
module pdcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/pdcd_eval.sv @@
module pdcd_eval import pdcd_pkg::*; (
  input  req_t   item,
  input  logic   in_range,
  input  logic   entry_on,
  input  entry_t word,
  output eval_t  res
);

  function automatic logic [DATA_W:0] widen(logic [DATA_W-1:0] v, logic [LEN_W-1:0] len);
    logic [DATA_W:0] w;
    case (len)
      LEN_S8:  w = {{(DATA_W-7){v[7]}}, v[7:0]};
      LEN_S16: w = {{(DATA_W-15){v[15]}}, v[15:0]};
      LEN_S32: w = {{(DATA_W-31){v[31]}}, v[31:0]};
      default: w = {1'b0, v};
    endcase
    return w;
  endfunction

  logic [DATA_W+HI_W-1:0] win_shifted;
  logic [DATA_W-1:0]      len_mask;
  logic [DATA_W-1:0]      cur;
  logic [DATA_W:0]        diff;
  logic [DATA_W-1:0]      mag;
  logic [DATA_W-1:0]      age;
  logic                   beats;

  // field extraction at stored offset and length
  always_comb begin
    win_shifted = {item.window_hi, item.window_lo} >> word.start_bit;
    if (word.field_len == '0 || word.field_len > LEN_MAX) begin
      len_mask = '0;
    end else if (word.field_len == LEN_MAX) begin
      len_mask = '1;
    end else begin
      len_mask = ~({DATA_W{1'b1}} << word.field_len);
    end
    cur = win_shifted[DATA_W-1:0] & len_mask;
  end

  // magnitude of change, one bit wider so unsigned fields cannot overflow
  always_comb begin
    diff  = widen(cur, word.field_len) - widen(word.shadow, word.field_len);
    mag   = diff[DATA_W] ? DATA_W'(-diff) : diff[DATA_W-1:0];
    beats = mag > word.deadband;
    age   = item.now_ns - word.last_time;
  end

  always_comb begin
    res                    = '0;
    res.wr_word            = word;
    res.rsp.outcome        = OUT_UNREGISTERED;
    res.rsp.report_entry   = item.slot;
    if (!in_range) begin
      res.rsp.outcome = OUT_UNREGISTERED;
    end else if (item.req_type == REQ_REGISTER) begin
      if (32'(item.device_index) >= NUM_DEVICES) begin
        res.rsp.outcome = OUT_UNREGISTERED;
      end else begin
        res.wr_word.start_bit  = item.start_bit;
        res.wr_word.field_len  = item.field_len;
        res.wr_word.out_only   = item.out_only;
        res.wr_word.device     = item.device_index;
        res.wr_word.deadband   = item.deadband;
        res.wr_word.interval   = item.hold_off_ns;
        res.wr_word.shadow     = '0;
        res.wr_word.last_time  = '0;
        res.wr_word.seen       = 1'b0;
        res.wr_en              = 1'b1;
        res.set_valid          = 1'b1;
        res.rsp.outcome        = OUT_REGISTERED;
        res.rsp.report_device  = item.device_index;
      end
    end else if (!entry_on) begin
      res.rsp.outcome = OUT_UNREGISTERED;
    end else begin
      res.rsp.report_device = word.device;
      if (word.out_only) begin
        res.rsp.outcome = OUT_OUTPUT;
      end else if (age < word.interval) begin
        res.rsp.outcome = OUT_RATE_LIMITED;
      end else if (!word.seen || beats) begin
        res.rsp.outcome       = word.seen ? OUT_CHANGED : OUT_INITIAL;
        res.rsp.report_value  = cur;
        res.wr_word.shadow    = cur;
        res.wr_word.last_time = item.now_ns;
        res.wr_word.seen      = 1'b1;
        res.wr_en             = 1'b1;
      end else begin
        res.rsp.outcome = OUT_UNCHANGED;
      end
    end
  end

endmodule
